/* hw/rtl/i2cra_pkg.sv */
// shared types and constants for the i2c register access master
package i2cra_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned ActionW = 2;
    localparam int unsigned StatusW = 3;
    localparam int unsigned CfgIdxW = 1;

    // command codes on the action field
    localparam logic [ActionW-1:0] ACT_TICK  = 2'd0;
    localparam logic [ActionW-1:0] ACT_WRITE = 2'd1;
    localparam logic [ActionW-1:0] ACT_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR    = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 1'd1;

    localparam logic [ByteW-1:0] DEV_ADDR_RST    = 8'h90;
    localparam logic [ByteW-1:0] ACK_TIMEOUT_RST = 8'd250;

    // completion status codes
    localparam logic [StatusW-1:0] STAT_OK          = 3'd0;
    localparam logic [StatusW-1:0] STAT_ADDR_NACK   = 3'd1;
    localparam logic [StatusW-1:0] STAT_REG_NACK    = 3'd2;
    localparam logic [StatusW-1:0] STAT_DATA_NACK   = 3'd3;
    localparam logic [StatusW-1:0] STAT_RADDR_NACK  = 3'd4;

    // one result of the sequencer
    typedef struct packed {
        logic               scl_out;
        logic               sda_out;
        logic               busy_res;
        logic               done_res;
        logic [StatusW-1:0] status;
        logic [ByteW-1:0]   read_data;
    } t_seq_res;

endpackage

/* hw/rtl/i2cra_if.sv */
// command and result channel interfaces
interface i2cra_in_if
    import i2cra_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ActionW-1:0] action;
    logic [ByteW-1:0]   reg_addr;
    logic [ByteW-1:0]   write_data;
    logic               sda_in;

    modport source (output valid, action, reg_addr, write_data, sda_in, input ready);
    modport sink   (input valid, action, reg_addr, write_data, sda_in, output ready);
endinterface

interface i2cra_out_if
    import i2cra_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               scl_out;
    logic               sda_out;
    logic               busy_res;
    logic               done_res;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   read_data;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, status, read_data,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, status, read_data,
                    output ready);
endinterface

/* hw/rtl/i2cra_seq.sv */
// bus sequencer: phase state, shift registers and config, one phase per step
module i2cra_seq
    import i2cra_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [ActionW-1:0] i_action,
    input  logic [ByteW-1:0]   i_reg_addr,
    input  logic [ByteW-1:0]   i_write_data,
    input  logic               i_sda_in,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [ByteW-1:0]   i_cfg_data,
    output t_seq_res           o_res
);

    localparam logic [4:0] PH_IDLE  = 5'd0;
    localparam logic [4:0] PH_ST1   = 5'd1;
    localparam logic [4:0] PH_ST2   = 5'd2;
    localparam logic [4:0] PH_ST3   = 5'd3;
    localparam logic [4:0] PH_TXD   = 5'd4;
    localparam logic [4:0] PH_TXH   = 5'd5;
    localparam logic [4:0] PH_TXL   = 5'd6;
    localparam logic [4:0] PH_AREL  = 5'd7;
    localparam logic [4:0] PH_AHI   = 5'd8;
    localparam logic [4:0] PH_APOLL = 5'd9;
    localparam logic [4:0] PH_RDL   = 5'd10;
    localparam logic [4:0] PH_RDH   = 5'd11;
    localparam logic [4:0] PH_NK1   = 5'd12;
    localparam logic [4:0] PH_NK2   = 5'd13;
    localparam logic [4:0] PH_NK3   = 5'd14;
    localparam logic [4:0] PH_SP1   = 5'd15;
    localparam logic [4:0] PH_SP2   = 5'd16;
    localparam logic [4:0] PH_SP3   = 5'd17;
    localparam logic [4:0] PH_SP4   = 5'd18;

    localparam logic [1:0] STG_ADDR  = 2'd0;
    localparam logic [1:0] STG_REG   = 2'd1;
    localparam logic [1:0] STG_DATA  = 2'd2;
    localparam logic [1:0] STG_RADDR = 2'd3;

    logic [4:0]         r_phase, n_phase;
    logic [3:0]         r_bit_idx, n_bit_idx;
    logic [ByteW-1:0]   r_tx, n_tx;
    logic [ByteW-1:0]   r_rx, n_rx;
    logic [ByteW-1:0]   r_ack_cnt, n_ack_cnt;
    logic [ByteW-1:0]   r_held_reg, n_held_reg;
    logic [ByteW-1:0]   r_held_data, n_held_data;
    logic               r_is_read, n_is_read;
    logic [StatusW-1:0] r_last_status, n_last_status;
    logic [1:0]         r_stage, n_stage;
    logic [StatusW-1:0] r_pend, n_pend;
    logic [ByteW-1:0]   r_read_hold, n_read_hold;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic               n_done;
    logic [ByteW-1:0]   r_dev_addr;
    logic [ByteW-1:0]   r_ack_to;

    // next state for one bus tick
    always_comb begin
        n_phase       = r_phase;
        n_bit_idx     = r_bit_idx;
        n_tx          = r_tx;
        n_rx          = r_rx;
        n_ack_cnt     = r_ack_cnt;
        n_held_reg    = r_held_reg;
        n_held_data   = r_held_data;
        n_is_read     = r_is_read;
        n_last_status = r_last_status;
        n_stage       = r_stage;
        n_pend        = r_pend;
        n_read_hold   = r_read_hold;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_done        = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_action == ACT_WRITE || i_action == ACT_READ) begin
                    n_held_reg  = i_reg_addr;
                    n_held_data = i_write_data;
                    n_is_read   = (i_action == ACT_READ);
                    n_stage     = STG_ADDR;
                    n_phase     = PH_ST1;
                end
            end
            PH_ST1: begin
                n_sda   = 1'b1;
                n_scl   = 1'b1;
                n_phase = PH_ST2;
            end
            PH_ST2: begin
                n_sda   = 1'b0;
                n_phase = PH_ST3;
            end
            PH_ST3: begin
                n_scl     = 1'b0;
                n_tx      = (r_stage == STG_RADDR) ? (r_dev_addr | 8'h01) : r_dev_addr;
                n_bit_idx = 4'd0;
                n_phase   = PH_TXD;
            end
            PH_TXD: begin
                n_scl   = 1'b0;
                n_sda   = r_tx[ByteW-1];
                n_phase = PH_TXH;
            end
            PH_TXH: begin
                n_scl   = 1'b1;
                n_phase = PH_TXL;
            end
            PH_TXL: begin
                n_scl     = 1'b0;
                n_tx      = {r_tx[ByteW-2:0], 1'b0};
                n_bit_idx = r_bit_idx + 4'd1;
                n_phase   = (n_bit_idx >= 4'd8) ? PH_AREL : PH_TXD;
            end
            PH_AREL: begin
                n_sda   = 1'b1;
                n_phase = PH_AHI;
            end
            PH_AHI: begin
                n_scl     = 1'b1;
                n_ack_cnt = '0;
                n_phase   = PH_APOLL;
            end
            PH_APOLL: begin
                if (!i_sda_in) begin
                    // acknowledged: move to the next byte of the sequence
                    n_scl = 1'b0;
                    case (r_stage)
                        STG_ADDR: begin
                            n_stage   = STG_REG;
                            n_tx      = r_held_reg;
                            n_bit_idx = 4'd0;
                            n_phase   = PH_TXD;
                        end
                        STG_REG: begin
                            if (r_is_read) begin
                                n_stage = STG_RADDR;
                                n_phase = PH_ST1;
                            end else begin
                                n_stage   = STG_DATA;
                                n_tx      = r_held_data;
                                n_bit_idx = 4'd0;
                                n_phase   = PH_TXD;
                            end
                        end
                        STG_DATA: begin
                            n_pend  = STAT_OK;
                            n_phase = PH_SP1;
                        end
                        default: begin
                            n_bit_idx = 4'd0;
                            n_rx      = '0;
                            n_phase   = PH_RDL;
                        end
                    endcase
                end else if (r_ack_cnt >= r_ack_to) begin
                    // give up: status is the failing byte plus one
                    n_pend  = {1'b0, r_stage} + 3'd1;
                    n_phase = PH_SP1;
                end else begin
                    n_ack_cnt = r_ack_cnt + 8'd1;
                end
            end
            PH_RDL: begin
                n_sda   = 1'b1;
                n_scl   = 1'b0;
                n_phase = PH_RDH;
            end
            PH_RDH: begin
                n_scl     = 1'b1;
                n_rx      = {r_rx[ByteW-2:0], i_sda_in};
                n_bit_idx = r_bit_idx + 4'd1;
                n_phase   = (n_bit_idx >= 4'd8) ? PH_NK1 : PH_RDL;
            end
            PH_NK1: begin
                n_scl   = 1'b0;
                n_sda   = 1'b1;
                n_phase = PH_NK2;
            end
            PH_NK2: begin
                n_scl   = 1'b1;
                n_phase = PH_NK3;
            end
            PH_NK3: begin
                n_scl   = 1'b0;
                n_pend  = STAT_OK;
                n_phase = PH_SP1;
            end
            PH_SP1: begin
                n_sda   = 1'b0;
                n_scl   = 1'b0;
                n_phase = PH_SP2;
            end
            PH_SP2: begin
                n_scl   = 1'b1;
                n_phase = PH_SP3;
            end
            PH_SP3: begin
                n_sda   = 1'b1;
                n_phase = PH_SP4;
            end
            PH_SP4: begin
                n_last_status = r_pend;
                if (r_pend == STAT_OK && r_is_read) begin
                    n_read_hold = r_rx;
                end
                n_done  = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                n_scl   = 1'b1;
                n_sda   = 1'b1;
                n_phase = PH_IDLE;
            end
        endcase
    end

    // result of this tick, registered by the top level
    assign o_res.scl_out   = n_scl;
    assign o_res.sda_out   = n_sda;
    assign o_res.busy_res  = (n_phase != PH_IDLE);
    assign o_res.done_res  = n_done;
    assign o_res.status    = n_last_status;
    assign o_res.read_data = n_read_hold;

    // sequencer state update on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_idx     <= '0;
            r_tx          <= '0;
            r_rx          <= '0;
            r_ack_cnt     <= '0;
            r_held_reg    <= '0;
            r_held_data   <= '0;
            r_is_read     <= 1'b0;
            r_last_status <= STAT_OK;
            r_stage       <= STG_ADDR;
            r_pend        <= STAT_OK;
            r_read_hold   <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bit_idx     <= n_bit_idx;
            r_tx          <= n_tx;
            r_rx          <= n_rx;
            r_ack_cnt     <= n_ack_cnt;
            r_held_reg    <= n_held_reg;
            r_held_data   <= n_held_data;
            r_is_read     <= n_is_read;
            r_last_status <= n_last_status;
            r_stage       <= n_stage;
            r_pend        <= n_pend;
            r_read_hold   <= n_read_hold;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
            r_ack_to   <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEV_ADDR:    r_dev_addr <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_to   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/i2c_register_access_master_core.sv */
// top level: input register, bus sequencer and result register
// path: a tick passes through the input register and then the result register
// throughput: 1 tick per cycle while the result channel is ready; the sequencer advances one phase per tick
// the input and result registers decouple the two channels, so a tick is taken into an empty
// input register while a finished result waits to be taken
// reset: synchronous active low, bus released, sequencer idle, config at defaults
module i2c_register_access_master_core
    import i2cra_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cra_in_if.sink           i_in,
    i2cra_out_if.source        o_out,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [ByteW-1:0]   i_cfg_data
);

    logic               r_in_valid;
    logic [ActionW-1:0] r_action;
    logic [ByteW-1:0]   r_reg_addr;
    logic [ByteW-1:0]   r_write_data;
    logic               r_sda_in;
    logic               r_out_valid;
    t_seq_res           r_res;
    t_seq_res           seq_res;
    logic               step;

    // a held tick moves on when the result register is free or being taken
    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_action     <= i_in.action;
            r_reg_addr   <= i_in.reg_addr;
            r_write_data <= i_in.write_data;
            r_sda_in     <= i_in.sda_in;
        end
    end

    i2cra_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_action     (r_action),
        .i_reg_addr   (r_reg_addr),
        .i_write_data (r_write_data),
        .i_sda_in     (r_sda_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_res        (seq_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= seq_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl_out   = r_res.scl_out;
    assign o_out.sda_out   = r_res.sda_out;
    assign o_out.busy_res  = r_res.busy_res;
    assign o_out.done_res  = r_res.done_res;
    assign o_out.status    = r_res.status;
    assign o_out.read_data = r_res.read_data;

endmodule

/* hw/rtl/i2cra_chk.sv */
// port-level checker for the i2c register access master, bound to the top level
module i2cra_chk
    import i2cra_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_scl_out,
    input logic               i_sda_out,
    input logic               i_busy_res,
    input logic               i_done_res,
    input logic [StatusW-1:0] i_status,
    input logic [ByteW-1:0]   i_read_data
);

    // no result is offered right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // a finished transaction leaves the master idle with both lines released
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res |-> !i_busy_res && i_scl_out && i_sda_out)
        else $error("done without idle released bus");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= STAT_RADDR_NACK)
        else $error("status code out of range");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_scl_out, i_sda_out, i_busy_res, i_done_res, i_status,
                        i_read_data}))
        else $error("stalled result changed");

endmodule

bind i2c_register_access_master_core i2cra_chk u_i2cra_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_scl_out   (o_out.scl_out),
    .i_sda_out   (o_out.sda_out),
    .i_busy_res  (o_out.busy_res),
    .i_done_res  (o_out.done_res),
    .i_status    (o_out.status),
    .i_read_data (o_out.read_data)
);
